@@ rtl/bcr_pkg.sv @@
// Shared constants and types of the bicubic resampler.
// No dependencies; used by every module under rtl.
package bcr_pkg;

  localparam int unsigned MaxWidth  = 256;
  localparam int unsigned MaxHeight = 256;
  localparam int unsigned MaxPlanes = 4;

  localparam int unsigned ColW   = $clog2(MaxWidth);
  localparam int unsigned RowW   = $clog2(MaxHeight);
  localparam int unsigned PlaneW = (MaxPlanes > 1) ? $clog2(MaxPlanes) : 1;
  localparam int unsigned AddrW  = PlaneW + RowW + ColW;
  localparam int unsigned Depth  = MaxPlanes * MaxHeight * MaxWidth;

  localparam int unsigned SampleW = 16;
  localparam int unsigned WgtW    = 18;
  localparam int unsigned PixelW  = 18;
  localparam int unsigned FracW   = 16;

  typedef logic signed [WgtW-1:0] wgt_t;

  // Operation codes carried in tuser.
  localparam logic OP_STORE   = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_IN_WIDTH  = 3'd0;
  localparam logic [2:0] REG_IN_HEIGHT = 3'd1;
  localparam logic [2:0] REG_CHANNELS  = 3'd2;
  localparam logic [2:0] REG_STEP_X    = 3'd3;
  localparam logic [2:0] REG_STEP_Y    = 3'd4;

  // Handshake between the sequencer and the weight unit.
  typedef struct packed {
    logic              start;
    logic [FracW-1:0]  frac;
  } wgt_req_t;

endpackage

@@ rtl/bcr_frame_store.sv @@
// Single-ported frame store; the read data is registered.
// Depends on bcr_pkg for depth and widths.
module bcr_frame_store (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [bcr_pkg::AddrW-1:0]   addr_i,
  input  logic [bcr_pkg::SampleW-1:0] wdata_i,
  output logic [bcr_pkg::SampleW-1:0] rdata_o
);

  logic [bcr_pkg::SampleW-1:0] mem [bcr_pkg::Depth];
  logic [bcr_pkg::SampleW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/bcr_weight_unit.sv @@
// Catmull-Rom weight unit: four Q4.14 weights from a 16-bit fraction, via t^2 and t^3.
// Depends on bcr_pkg for widths and the request struct.
module bcr_weight_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bcr_pkg::wgt_req_t req_i,
  output logic              done_o,
  output bcr_pkg::wgt_t     w_o [4]
);

  localparam int unsigned PolyW = 54;

  logic [bcr_pkg::FracW-1:0]   t_q;
  logic [2*bcr_pkg::FracW-1:0] t2_q;
  logic [3*bcr_pkg::FracW-1:0] t3_q;
  logic                        s1_q, s2_q, done_q;
  bcr_pkg::wgt_t               w_q [4];

  logic signed [PolyW-1:0] a, b, c, one;
  logic signed [PolyW-1:0] p [4];
  logic signed [PolyW-1:0] r [4];

  always_comb begin
    a   = signed'(PolyW'(t3_q));
    b   = signed'(PolyW'({t2_q, 16'b0}));
    c   = signed'(PolyW'({t_q, 32'b0}));
    one = signed'(PolyW'(1)) <<< 49;
    p[0] = -a + (b <<< 1) - c;
    p[1] = (a <<< 1) + a - (b <<< 2) - b + one;
    p[2] = -((a <<< 1) + a) + (b <<< 2) + c;
    p[3] = a - b;
    for (int i = 0; i < 4; i++) begin
      // Round half up to Q4.14: add half an LSB, then floor.
      r[i] = (p[i] + (signed'(PolyW'(1)) <<< 34)) >>> 35;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= 1'b0;
      s2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      s1_q   <= req_i.start;
      s2_q   <= s1_q;
      done_q <= s2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      t_q  <= req_i.frac;
      t2_q <= req_i.frac * req_i.frac;
    end
    if (s1_q) begin
      t3_q <= t2_q * t_q;
    end
    if (s2_q) begin
      for (int i = 0; i < 4; i++) begin
        w_q[i] <= r[i][bcr_pkg::WgtW-1:0];
      end
    end
  end

  assign done_o = done_q;
  assign w_o    = w_q;

endmodule

@@ rtl/bicubic_catmull_rom_resampler_unit.sv @@
// Top level of the bicubic resampler: stream ports, registers, sequencer, MAC.
// Depends on bcr_pkg, bcr_frame_store and bcr_weight_unit.
//
// Use: requests arrive on s_axis; tuser selects a sample store or a pixel compute.
// An in-range store is written into the frame store in the cycle it is accepted
// and yields no result; the next request is taken in the following cycle.
// A compute yields one pixel on m_axis. It multiplies the output coordinates by
// the step registers, runs the shared weight unit for x and then y, then reads the
// sixteen neighbours from the single frame memory port, one per cycle, through a
// two-stage MAC.
// A compute on an unused plane skips the weights and taps and gives zero.
// One request is in work at a time.
// The result waits in an output register; stores are still taken while it
// waits, and a finished compute holds until m_axis_tready frees that register.
// Reset returns the registers to 256, 256, 1, 0x10000, 0x10000 and empties
// the output; the frame store content is undefined until written.
// Configuration is by APB at byte addresses 4*i and is always ready.
module bicubic_catmull_rom_resampler_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] plane, [9:2] src_row, [17:10] src_col, [33:18] sample_value,
  // [45:34] dst_row, [57:46] dst_col, [63:58] zero
  input  logic [63:0] s_axis_tdata,
  // [0] operation
  input  logic        s_axis_tuser,
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [17:0] pixel_value, [23:18] zero
  output logic [23:0] m_axis_tdata
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_WX   = 3'd1;
  localparam logic [2:0] ST_WY   = 3'd2;
  localparam logic [2:0] ST_TAPS = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  localparam int unsigned PosW = 36;
  localparam int unsigned IdxW = PosW - bcr_pkg::FracW;
  localparam int unsigned AccW = 54;

  // Registers
  logic [8:0]  in_width_q, in_height_q;
  logic [2:0]  channels_q;
  logic [23:0] step_x_q, step_y_q;

  logic [2:0]  state_q, state_d;
  logic        wbusy_q;
  logic [4:0]  cnt_q;
  logic [1:0]  plane_q;
  logic [PosW-1:0] u_q, v_q;
  bcr_pkg::wgt_t wx_q [4];
  bcr_pkg::wgt_t wy_q [4];
  logic        vld1_q, vld2_q;
  logic [3:0]  tap1_q, tap2_q;
  logic signed [34:0]     p1_q;
  logic signed [AccW-1:0] acc_q;
  logic        out_valid_q;
  logic [bcr_pkg::PixelW-1:0] out_q;

  // Effective register values
  logic [8:0] width_eff, height_eff;
  logic [2:0] planes_eff;

  always_comb begin
    width_eff  = (in_width_q == 9'd0) ? 9'd1 :
                 (in_width_q > 9'(bcr_pkg::MaxWidth)) ? 9'(bcr_pkg::MaxWidth) : in_width_q;
    height_eff = (in_height_q == 9'd0) ? 9'd1 :
                 (in_height_q > 9'(bcr_pkg::MaxHeight)) ? 9'(bcr_pkg::MaxHeight) : in_height_q;
    planes_eff = (channels_q == 3'd0) ? 3'd1 :
                 (channels_q > 3'(bcr_pkg::MaxPlanes)) ? 3'(bcr_pkg::MaxPlanes) : channels_q;
  end

  // Request fields
  logic [1:0]  f_plane;
  logic [7:0]  f_src_row, f_src_col;
  logic [15:0] f_sample;
  logic [11:0] f_dst_row, f_dst_col;

  assign f_plane   = s_axis_tdata[1:0];
  assign f_src_row = s_axis_tdata[9:2];
  assign f_src_col = s_axis_tdata[17:10];
  assign f_sample  = s_axis_tdata[33:18];
  assign f_dst_row = s_axis_tdata[45:34];
  assign f_dst_col = s_axis_tdata[57:46];

  logic in_acc, is_store, store_ok, plane_ok;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign is_store = (s_axis_tuser == bcr_pkg::OP_STORE);
  assign plane_ok = (3'(f_plane) < planes_eff);
  assign store_ok = plane_ok && (9'(f_src_row) < height_eff) && (9'(f_src_col) < width_eff);

  // APB
  logic cfg_we;
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[4:2])
      bcr_pkg::REG_IN_WIDTH:  prdata = 32'(in_width_q);
      bcr_pkg::REG_IN_HEIGHT: prdata = 32'(in_height_q);
      bcr_pkg::REG_CHANNELS:  prdata = 32'(channels_q);
      bcr_pkg::REG_STEP_X:    prdata = 32'(step_x_q);
      bcr_pkg::REG_STEP_Y:    prdata = 32'(step_y_q);
      default:                prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_width_q  <= 9'd256;
      in_height_q <= 9'd256;
      channels_q  <= 3'd1;
      step_x_q    <= 24'h010000;
      step_y_q    <= 24'h010000;
    end else if (cfg_we) begin
      case (paddr[4:2])
        bcr_pkg::REG_IN_WIDTH:  in_width_q  <= pwdata[8:0];
        bcr_pkg::REG_IN_HEIGHT: in_height_q <= pwdata[8:0];
        bcr_pkg::REG_CHANNELS:  channels_q  <= pwdata[2:0];
        bcr_pkg::REG_STEP_X:    step_x_q    <= pwdata[23:0];
        bcr_pkg::REG_STEP_Y:    step_y_q    <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  // Weight unit
  bcr_pkg::wgt_req_t wreq;
  logic              wdone;
  bcr_pkg::wgt_t     wout [4];

  always_comb begin
    wreq.start = ((state_q == ST_WX) || (state_q == ST_WY)) && !wbusy_q;
    wreq.frac  = (state_q == ST_WX) ? u_q[bcr_pkg::FracW-1:0] : v_q[bcr_pkg::FracW-1:0];
  end

  bcr_weight_unit u_wgt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (wreq),
    .done_o (wdone),
    .w_o    (wout)
  );

  // Neighbour address for the current tap, clamped to the image.
  function automatic logic [7:0] clamp_pos(input logic [IdxW-1:0] base,
                                           input logic [1:0] off,
                                           input logic [8:0] lim);
    logic signed [IdxW+1:0] pos;
    logic signed [IdxW+1:0] hi;
    pos = signed'((IdxW+2)'(base)) + signed'((IdxW+2)'(off)) - (IdxW+2)'(1);
    hi  = signed'((IdxW+2)'(lim)) - (IdxW+2)'(1);
    if (pos < 0) begin
      clamp_pos = 8'd0;
    end else if (pos > hi) begin
      clamp_pos = hi[7:0];
    end else begin
      clamp_pos = pos[7:0];
    end
  endfunction

  logic [7:0] tap_row, tap_col;
  logic       mem_we;
  logic [bcr_pkg::AddrW-1:0] mem_addr;
  logic [bcr_pkg::SampleW-1:0] mem_rdata;

  assign tap_row = clamp_pos(v_q[PosW-1:bcr_pkg::FracW], cnt_q[3:2], height_eff);
  assign tap_col = clamp_pos(u_q[PosW-1:bcr_pkg::FracW], cnt_q[1:0], width_eff);
  assign mem_we  = in_acc && is_store && store_ok;
  assign mem_addr = (state_q == ST_IDLE) ? {f_plane, f_src_row, f_src_col}
                                         : {plane_q, tap_row, tap_col};

  bcr_frame_store u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (f_sample),
    .rdata_o (mem_rdata)
  );

  logic issue;
  assign issue = (state_q == ST_TAPS) && (cnt_q < 5'd16);

  // Rounding and saturation of the sum
  logic signed [AccW-1:0] rnd;
  logic [bcr_pkg::PixelW-1:0] pix;
  always_comb begin
    rnd = (acc_q + (signed'(AccW'(1)) <<< 27)) >>> 28;
    if (rnd < -(signed'(AccW'(1)) <<< 17)) begin
      pix = {1'b1, 17'd0};
    end else if (rnd > (signed'(AccW'(1)) <<< 17) - AccW'(1)) begin
      pix = {1'b0, {17{1'b1}}};
    end else begin
      pix = rnd[bcr_pkg::PixelW-1:0];
    end
  end

  logic out_free;
  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc && !is_store) begin
        state_d = plane_ok ? ST_WX : ST_FIN;
      end
      ST_WX:   if (wdone) state_d = ST_WY;
      ST_WY:   if (wdone) state_d = ST_TAPS;
      ST_TAPS: if (cnt_q == 5'd17) state_d = ST_FIN;
      ST_FIN:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wbusy_q     <= 1'b0;
      cnt_q       <= 5'd0;
      vld1_q      <= 1'b0;
      vld2_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (wreq.start) begin
        wbusy_q <= 1'b1;
      end else if (wdone) begin
        wbusy_q <= 1'b0;
      end
      if (state_q == ST_TAPS) begin
        cnt_q <= cnt_q + 5'd1;
      end else begin
        cnt_q <= 5'd0;
      end
      vld1_q <= issue;
      vld2_q <= vld1_q;
      if ((state_q == ST_FIN) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      plane_q <= f_plane;
      u_q     <= PosW'(f_dst_col * step_x_q);
      v_q     <= PosW'(f_dst_row * step_y_q);
      acc_q   <= '0;
    end else if (vld2_q) begin
      acc_q <= acc_q + AccW'(p1_q * wx_q[tap2_q[1:0]]);
    end
    if ((state_q == ST_WX) && wdone) wx_q <= wout;
    if ((state_q == ST_WY) && wdone) wy_q <= wout;
    tap1_q <= cnt_q[3:0];
    tap2_q <= tap1_q;
    if (vld1_q) begin
      p1_q <= signed'({1'b0, mem_rdata}) * wy_q[tap1_q[3:2]];
    end
    if ((state_q == ST_FIN) && out_free) begin
      out_q <= pix;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_q};

  // The frame store is only written while no compute is in work.
  a_we_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_IDLE))
    else $error("frame store written during a compute");

  // Every MAC step belongs to the tap phase.
  a_mac_taps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld2_q |-> (state_q == ST_TAPS))
    else $error("MAC step outside the tap phase");

  // Weights are only returned while the sequencer waits for them.
  a_wdone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wdone |-> ((state_q == ST_WX) || (state_q == ST_WY)))
    else $error("weights returned unexpectedly");

  // A finished pixel with a free output register is shown next cycle.
  a_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_FIN) && out_free) |=> out_valid_q)
    else $error("finished pixel lost");

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for bicubic_catmull_rom_resampler_unit: directed table, then random phases.
// Keeps its own copy of the frame store and registers; predicts random-phase pixels from them.
// Depends on bcr_pkg and the RTL under rtl.
`timescale 1ns / 100ps
module testbench;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned Settle     = 40;
  localparam int unsigned NumRows    = 12;
  localparam int unsigned PhaseItems = 115;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  bicubic_catmull_rom_resampler_unit uut (.*);

  // Mirror of the frame store, with a flag per entry that marks it as written.
  logic [15:0] sample_mirror [bcr_pkg::Depth];
  bit          sample_written [bcr_pkg::Depth];
  int unsigned cfg_w = 256, cfg_h = 256, cfg_ch = 1, cfg_sx = 32'h10000, cfg_sy = 32'h10000;
  logic signed [bcr_pkg::PixelW-1:0] pixels_due [$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned sent = 0;
  bit          calm = 1'b0;

  typedef struct packed {
    logic                              op;
    logic [1:0]                        plane;
    logic [7:0]                        row;
    logic [7:0]                        col;
    logic [15:0]                       val;
    logic [11:0]                       drow;
    logic [11:0]                       dcol;
    logic                              typed;
    logic signed [bcr_pkg::PixelW-1:0] want;
  } stim_row_t;

  // Directed rows run with the registers as they come out of reset (unit steps).
  stim_row_t directed_rows [NumRows] = '{
    '{bcr_pkg::OP_STORE,   2'd0, 8'd0,   8'd0,   16'hFFFF, 12'd0,    12'd0,    1'b0, 18'sd0},
    '{bcr_pkg::OP_COMPUTE, 2'd0, 8'd0,   8'd0,   16'h0,    12'd0,    12'd0,    1'b1, 18'sd65535},
    '{bcr_pkg::OP_STORE,   2'd0, 8'd255, 8'd255, 16'h1234, 12'd0,    12'd0,    1'b0, 18'sd0},
    '{bcr_pkg::OP_COMPUTE, 2'd0, 8'd0,   8'd0,   16'h0,    12'd255,  12'd255,  1'b1, 18'sh1234},
    '{bcr_pkg::OP_COMPUTE, 2'd0, 8'd0,   8'd0,   16'h0,    12'd4095, 12'd4095, 1'b1, 18'sh1234},
    '{bcr_pkg::OP_STORE,   2'd0, 8'd5,   8'd7,   16'h0000, 12'd0,    12'd0,    1'b0, 18'sd0},
    '{bcr_pkg::OP_COMPUTE, 2'd0, 8'd0,   8'd0,   16'h0,    12'd5,    12'd7,    1'b1, 18'sd0},
    '{bcr_pkg::OP_STORE,   2'd1, 8'd3,   8'd3,   16'hABCD, 12'd0,    12'd0,    1'b0, 18'sd0},
    '{bcr_pkg::OP_COMPUTE, 2'd3, 8'd0,   8'd0,   16'h0,    12'd17,   12'd9,    1'b1, 18'sd0},
    '{bcr_pkg::OP_COMPUTE, 2'd1, 8'd0,   8'd0,   16'h0,    12'd3,    12'd3,    1'b1, 18'sd0},
    '{bcr_pkg::OP_STORE,   2'd0, 8'd0,   8'd255, 16'h8000, 12'd0,    12'd0,    1'b0, 18'sd0},
    '{bcr_pkg::OP_COMPUTE, 2'd0, 8'd0,   8'd0,   16'h0,    12'd0,    12'd255,  1'b1, 18'sd32768}
  };

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: compare each accepted pixel with the oldest prediction.
  always @(posedge clk_i) begin : pixel_check
    logic signed [bcr_pkg::PixelW-1:0] want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pixels_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected pixel, expected none, actual %0d", $time,
                 $signed(m_axis_tdata[bcr_pkg::PixelW-1:0]));
      end else begin
        want = pixels_due.pop_front();
        if (want !== $signed(m_axis_tdata[bcr_pkg::PixelW-1:0])) begin
          errors++;
          $display("%0t: pixel_value mismatch, expected %0d, actual %0d", $time, want,
                   $signed(m_axis_tdata[bcr_pkg::PixelW-1:0]));
        end
      end
    end
    m_axis_tready <= calm || ($urandom_range(99) >= 20);
  end

  function automatic int unsigned clip(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic int unsigned store_addr(int unsigned plane, int unsigned row,
                                             int unsigned col);
    return (plane * bcr_pkg::MaxHeight + row) * bcr_pkg::MaxWidth + col;
  endfunction

  // Catmull-Rom weight k of fraction t in Q4.14, rounded half up.
  function automatic longint cubic_weight(longint t, int k);
    longint t2, t3, v;
    t2 = t * t;
    t3 = t2 * t;
    case (k)
      0:       v = -t3 + 2 * t2 * 65536 - t * (longint'(1) << 32);
      1:       v = 3 * t3 - 5 * t2 * 65536 + (longint'(1) << 49);
      2:       v = -3 * t3 + 4 * t2 * 65536 + t * (longint'(1) << 32);
      default: v = t3 - t2 * 65536;
    endcase
    return (v + (longint'(1) << 34)) >>> 35;
  endfunction

  // Index of tap k around base b, clamped to the image edge.
  function automatic int unsigned tap_index(longint b, int k, int unsigned lim);
    longint v;
    v = b + k - 1;
    if (v < 0) return 0;
    if (v > lim - 1) return lim - 1;
    return int'(v);
  endfunction

  function automatic logic signed [bcr_pkg::PixelW-1:0] predict_pixel(int unsigned plane,
      int unsigned drow, int unsigned dcol);
    longint u, v, sum, res;
    int unsigned sy, sx;
    sum = 0;
    if (plane >= clip(cfg_ch, bcr_pkg::MaxPlanes)) return '0;
    u = longint'(dcol) * longint'(cfg_sx);
    v = longint'(drow) * longint'(cfg_sy);
    for (int m = 0; m < 4; m++) begin
      sy = tap_index(v >>> 16, m, clip(cfg_h, bcr_pkg::MaxHeight));
      for (int n = 0; n < 4; n++) begin
        sx = tap_index(u >>> 16, n, clip(cfg_w, bcr_pkg::MaxWidth));
        sum += longint'(sample_mirror[store_addr(plane, sy, sx)])
               * cubic_weight(v & 16'hFFFF, m) * cubic_weight(u & 16'hFFFF, n);
      end
    end
    res = (sum + (longint'(1) << 27)) >>> 28;
    if (res < -131072) res = -131072;
    if (res > 131071) res = 131071;
    return res[bcr_pkg::PixelW-1:0];
  endfunction

  task automatic send_request(logic op, int unsigned plane, int unsigned row, int unsigned col,
                              int unsigned val, int unsigned drow, int unsigned dcol,
                              bit typed, logic signed [bcr_pkg::PixelW-1:0] want);
    while (!calm && $urandom_range(99) < 20) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {6'd0, dcol[11:0], drow[11:0], val[15:0], col[7:0], row[7:0], plane[1:0]};
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
    if (op == bcr_pkg::OP_STORE) begin
      if (plane < clip(cfg_ch, bcr_pkg::MaxPlanes) && row < clip(cfg_h, bcr_pkg::MaxHeight)
          && col < clip(cfg_w, bcr_pkg::MaxWidth)) begin
        sample_mirror[store_addr(plane, row, col)] = val[15:0];
        sample_written[store_addr(plane, row, col)] = 1'b1;
      end
    end else begin
      pixels_due.push_back(typed ? want : predict_pixel(plane, drow, dcol));
    end
  endtask

  // A compute on a used plane first stores any of its sixteen neighbours that were never written.
  task automatic compute_pixel(int unsigned plane, int unsigned drow, int unsigned dcol,
                               bit typed, logic signed [bcr_pkg::PixelW-1:0] want);
    int unsigned sy, sx;
    if (plane < clip(cfg_ch, bcr_pkg::MaxPlanes)) begin
      for (int m = 0; m < 4; m++) begin
        sy = tap_index((longint'(drow) * cfg_sy) >>> 16, m, clip(cfg_h, bcr_pkg::MaxHeight));
        for (int n = 0; n < 4; n++) begin
          sx = tap_index((longint'(dcol) * cfg_sx) >>> 16, n, clip(cfg_w, bcr_pkg::MaxWidth));
          if (!sample_written[store_addr(plane, sy, sx)])
            send_request(bcr_pkg::OP_STORE, plane, sy, sx, $urandom_range(65535), 0, 0,
                         1'b0, '0);
        end
      end
    end
    send_request(bcr_pkg::OP_COMPUTE, plane, 0, 0, 0, drow, dcol, typed, want);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [2:0] idx, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_geometry(int unsigned w, int unsigned h, int unsigned ch,
                              int unsigned sx, int unsigned sy);
    drain_results();
    apb_write(bcr_pkg::REG_IN_WIDTH, w);
    apb_write(bcr_pkg::REG_IN_HEIGHT, h);
    apb_write(bcr_pkg::REG_CHANNELS, ch);
    apb_write(bcr_pkg::REG_STEP_X, sx);
    apb_write(bcr_pkg::REG_STEP_Y, sy);
    cfg_w  = w & 9'h1FF;
    cfg_h  = h & 9'h1FF;
    cfg_ch = ch & 3'h7;
    cfg_sx = sx & 24'hFFFFFF;
    cfg_sy = sy & 24'hFFFFFF;
  endtask

  initial begin
    int unsigned w, h, ch, sx, sy, pick, lim;
    stim_row_t r;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumRows; i++) begin
      r = directed_rows[i];
      if (r.op == bcr_pkg::OP_STORE)
        send_request(bcr_pkg::OP_STORE, r.plane, r.row, r.col, r.val, 0, 0, 1'b0, '0);
      else
        compute_pixel(r.plane, r.drow, r.dcol, r.typed, r.want);
    end

    for (int k = 0; k < 12; k++) begin
      case (k)
        0: begin w = 1;   h = 1;   ch = 4; sx = 0;         sy = 0;         end
        1: begin w = 0;   h = 511; ch = 0; sx = 24'hFFFFFF; sy = 1;         end
        2: begin w = 256; h = 256; ch = 7; sx = 24'h8000;   sy = 24'h18000; end
        3: begin w = 4;   h = 4;   ch = 5; sx = 24'hFFFFFF; sy = 24'hFFFFFF; end
        default: begin
          w  = ($urandom_range(3) == 0) ? $urandom_range(511) : $urandom_range(1, 16);
          h  = ($urandom_range(3) == 0) ? $urandom_range(511) : $urandom_range(1, 16);
          ch = $urandom_range(7);
          sx = ($urandom_range(2) == 0) ? $urandom_range(24'hFFFFFF) : $urandom_range(24'h30000);
          sy = ($urandom_range(2) == 0) ? $urandom_range(24'hFFFFFF) : $urandom_range(24'h30000);
        end
      endcase
      set_geometry(w, h, ch, sx, sy);
      calm = (k == 5);
      // Neighbour stores count towards the budget of each phase.
      while (sent < NumRows + (k + 1) * PhaseItems) begin
        pick = $urandom_range(99);
        lim  = ($urandom_range(1) == 0) ? 63 : 4095;
        if (pick < 60)
          compute_pixel($urandom_range(clip(cfg_ch, bcr_pkg::MaxPlanes) - 1),
                        $urandom_range(lim), $urandom_range(lim), 1'b0, '0);
        else if (pick < 70)
          compute_pixel($urandom_range(3), $urandom_range(4095), $urandom_range(4095),
                        1'b0, '0);
        else
          send_request(bcr_pkg::OP_STORE, $urandom_range(3), $urandom_range(255),
                       $urandom_range(255), $urandom_range(65535), $urandom_range(4095),
                       $urandom_range(4095), 1'b0, '0);
      end
      calm = 1'b0;
    end

    drain_results();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/bcr_pkg.sv
rtl/bcr_frame_store.sv
rtl/bcr_weight_unit.sv
rtl/bicubic_catmull_rom_resampler_unit.sv
bench/testbench.sv
